FILE: design/is_pkg.sv
// Shared constants and types of the insertion sorter.
package is_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int VALUE_W      = 32;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        t_value value;
        logic   last;
    } t_item;

endpackage

FILE: design/insertion_sorter.sv
// Top level of the streaming insertion sorter.
//
//  channel   | direction | tdata             | tlast       | tuser
//  ----------+-----------+-------------------+-------------+---------
//  s_axis    | in        | value[31:0]       | last        | -
//  m_axis    | out       | sorted_value[31:0]| end_of_set  | dropped
//
// A set streams in at one item per cycle while the front queue has room: the queue
// stores each item and the cell row inserts it from there while it is not draining.
// The last item starts a drain of the set (at most MAX_ELEMENTS items) through the output
// register; the row blocks the queue during the drain, which then takes up to QUEUE_DEPTH further items.
// Reset (i_rst_n low, synchronous) empties the queue, the row count, the overflow
// flag and the output register. A stall on m_axis holds the drain.
module insertion_sorter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [is_pkg::VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                      s_axis_tlast,    // last
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [is_pkg::VALUE_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic                      m_axis_tlast,    // end_of_set
    output logic                      m_axis_tuser     // [0] dropped
);
    import is_pkg::*;

    t_item  in_item;
    t_item  q_item;
    logic   q_valid;
    logic   q_ready;
    t_value out_value;

    // Pack the input channel into one queue entry.
    assign in_item.value = t_value'(s_axis_tdata);
    assign in_item.last  = s_axis_tlast;

    is_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_axis_tvalid),
        .o_push_ready (s_axis_tready),
        .i_push_item  (in_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    // Insert, then drain each set smallest first.
    is_insert_row u_row (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (q_valid),
        .o_item_ready  (q_ready),
        .i_item        (q_item),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_value   (out_value),
        .o_out_end     (m_axis_tlast),
        .o_out_dropped (m_axis_tuser)
    );

    assign m_axis_tdata = VALUE_W'(out_value);

endmodule

FILE: design/is_queue.sv
// Front queue: accepts input items and holds them for the insertion row.
module is_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  is_pkg::t_item i_push_item,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output is_pkg::t_item o_pop_item
);
    import is_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? QPTR_W'((QCNT_W'(r_wr_ptr) + 1'b1) % QUEUE_DEPTH) : r_wr_ptr;
        n_rd_ptr = pop  ? QPTR_W'((QCNT_W'(r_rd_ptr) + 1'b1) % QUEUE_DEPTH) : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

FILE: design/is_insert_row.sv
// Back end: row of compare-and-shift cells, drain sequencer and output register.
module is_insert_row (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_valid,
    output logic          o_item_ready,
    input  is_pkg::t_item i_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output is_pkg::t_value o_out_value,
    output logic          o_out_end,
    output logic          o_out_dropped
);
    import is_pkg::*;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_value           r_store [MAX_ELEMENTS];
    t_value           n_store [MAX_ELEMENTS];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_out_valid;
    logic             n_out_valid;
    t_value           r_out_value;
    t_value           n_out_value;
    logic             r_out_end;
    logic             n_out_end;
    logic             r_out_dropped;
    logic             n_out_dropped;
    logic [MAX_ELEMENTS-1:0] gt;
    logic             pop;
    logic             room;
    logic             load;

    assign o_item_ready  = (r_state == ST_FILL);
    assign pop           = o_item_ready && i_item_valid;
    assign room          = (r_count < CNT_W'(MAX_ELEMENTS));
    assign load          = (r_state == ST_DRAIN) && (!r_out_valid || i_out_ready);
    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_out_end     = r_out_end;
    assign o_out_dropped = r_out_dropped;

    // Each cell flags an occupied entry greater than the incoming value.
    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            gt[i] = (r_count > CNT_W'(i)) && (r_store[i] > i_item.value);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_store       = r_store;
        n_count       = r_count;
        n_ovf         = r_ovf;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_value   = r_out_value;
        n_out_end     = r_out_end;
        n_out_dropped = r_out_dropped;
        unique case (r_state)
            ST_FILL: begin
                if (pop) begin
                    if (room) begin
                        // Shift greater entries up one cell, drop the value into the gap.
                        for (int i = 0; i < MAX_ELEMENTS; i++) begin
                            if (gt[i] || (r_count == CNT_W'(i))) begin
                                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                                    n_store[i] = r_store[(i > 0) ? i - 1 : 0];
                                end else begin
                                    n_store[i] = i_item.value;
                                end
                            end
                        end
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (load) begin
                    // Move the head into the output register and advance the row.
                    n_out_valid   = 1'b1;
                    n_out_value   = r_store[0];
                    n_out_end     = (r_count == CNT_W'(1));
                    n_out_dropped = r_ovf;
                    for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
                        n_store[i] = r_store[i + 1];
                    end
                    n_count = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_ovf   = 1'b0;
                        n_state = ST_FILL;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_store       <= n_store;
        r_out_value   <= n_out_value;
        r_out_end     <= n_out_end;
        r_out_dropped <= n_out_dropped;
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: dv/insertion_sorter_tb.sv
// Self-checking testbench for the streaming insertion sorter.
module insertion_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import is_pkg::*;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 2 * MAX_ELEMENTS + 8;

    // One sorted item as it should leave m_axis.
    typedef struct {
        t_value value;
        logic   end_of_set;
        logic   dropped;
    } t_sorted;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata  = '0;     // [31:0] value
    logic               s_axis_tlast  = 1'b0;   // last
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VALUE_W-1:0] m_axis_tdata;           // [31:0] sorted_value
    logic               m_axis_tlast;           // end_of_set
    logic               m_axis_tuser;           // [0] dropped

    insertion_sorter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Stimulus and expectations
    t_item   pending_items[$];
    t_sorted sorted_expect[$];

    // Shadow of the sorter state
    t_value  row_values[MAX_ELEMENTS];
    int      row_count    = 0;
    logic    row_overflow = 1'b0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic recv_hold_req  = 1'b0;
    int   recv_hold_left = 0;
    logic item_taken     = 1'b0;

    int fail_count      = 0;
    int items_accepted  = 0;
    int sets_accepted   = 0;
    int overflow_sets   = 0;
    int results_checked = 0;

    // Insert one accepted item into the shadow row; on the last item of a set,
    // queue the whole row smallest first and clear it.
    function automatic void sort_accepted_item(t_value v, logic last);
        int pos;
        if (row_count < MAX_ELEMENTS) begin
            pos = row_count;
            // Stop at the first entry not greater than v so equal values keep
            // their arrival order.
            while (pos > 0 && row_values[pos-1] > v) begin
                row_values[pos] = row_values[pos-1];
                pos--;
            end
            row_values[pos] = v;
            row_count++;
        end else begin
            row_overflow = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < row_count; k++)
                sorted_expect.push_back('{row_values[k], k == row_count - 1,
                                          row_overflow});
            sets_accepted++;
            if (row_overflow)
                overflow_sets++;
            row_count    = 0;
            row_overflow = 1'b0;
        end
    endfunction

    // Monitor: take in accepted items and check every sorted item against the
    // oldest expectation.
    always @(posedge i_clk) begin
        t_sorted want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                items_accepted++;
                sort_accepted_item($signed(s_axis_tdata), s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_expect.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected sorted item: value %0d end %0b dropped %0b",
                             $time, $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                end else begin
                    want = sorted_expect.pop_front();
                    results_checked++;
                    if ($signed(m_axis_tdata) !== want.value
                            || m_axis_tlast !== want.end_of_set
                            || m_axis_tuser !== want.dropped) begin
                        fail_count++;
                        $display({"%0t: sorted item mismatch: expected value %0d end %0b ",
                                  "dropped %0b, got value %0d end %0b dropped %0b"},
                                 $time, want.value, want.end_of_set, want.dropped,
                                 $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                    end
                end
            end
        end
        item_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Driver: hold the offered item until taken, then offer the next one or idle.
    always @(negedge i_clk) begin
        t_item next_item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || item_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.value;
                s_axis_tlast  <= next_item.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps running.
    always @(negedge i_clk) begin
        if (recv_hold_left != 0) begin
            recv_hold_left <= recv_hold_left - 1;
        end else if (recv_hold_req) begin
            recv_hold_left <= LONG_HOLD_CYCLES;
            recv_hold_req  <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= recv_hold_left == 0 && $urandom_range(0, 99) >= recv_stall_pct;
    end

    function automatic t_value random_value();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2:    return $signed($urandom_range(0, 15)) - 8;    // many repeats
            3: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    // Queue whole sets until at least min_items items are pending for this phase.
    task automatic queue_random_sets(int min_items);
        int queued;
        int set_size;
        int pick;
        queued = 0;
        while (queued < min_items) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                set_size = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4);
            else if (pick == 1)
                set_size = MAX_ELEMENTS;
            else if (pick == 2)
                set_size = 1;
            else
                set_size = $urandom_range(2, MAX_ELEMENTS - 1);
            for (int k = 0; k < set_size; k++)
                pending_items.push_back('{random_value(), k == set_size - 1});
            queued += set_size;
        end
    endtask

    // Pause the sender until every item went in and every sorted item came out.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_items.size() != 0 || s_axis_tvalid || sorted_expect.size() != 0);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone extremes, reversed input, equal values, overflow.
        pending_items.push_back('{32'h7fff_ffff, 1'b1});
        pending_items.push_back('{32'h8000_0000, 1'b1});
        pending_items.push_back('{32'sd3, 1'b0});
        pending_items.push_back('{32'sd2, 1'b0});
        pending_items.push_back('{32'sd1, 1'b1});
        pending_items.push_back('{32'sd0, 1'b0});
        pending_items.push_back('{-32'sd1, 1'b0});
        pending_items.push_back('{32'sd0, 1'b0});
        pending_items.push_back('{-32'sd1, 1'b1});
        // Seventeen items: the last one finds the row full and is dropped.
        for (int k = 0; k <= MAX_ELEMENTS; k++) begin
            if (k == 0)
                pending_items.push_back('{32'h7fff_ffff, 1'b0});
            else if (k == MAX_ELEMENTS - 1)
                pending_items.push_back('{32'h8000_0000, 1'b0});
            else if (k == MAX_ELEMENTS)
                pending_items.push_back('{32'sd42, 1'b1});
            else
                pending_items.push_back('{1000 - 37 * (k % 9), 1'b0});
        end
        wait_drained();

        // Back to back on both sides.
        queue_random_sets(52);
        wait_drained();

        // Sparse sender.
        send_idle_pct = 81;
        queue_random_sets(52);
        wait_drained();

        // Heavy back-pressure.
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        queue_random_sets(52);
        wait_drained();

        // Both sides idle now and then.
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        queue_random_sets(52);
        wait_drained();

        // Block the output for a long stretch while the sender keeps pushing,
        // so the row and front queue fill up and stall s_axis.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_req  = 1'b1;
        queue_random_sets(52);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        #1;
        if (sorted_expect.size() != 0) begin
            fail_count++;
            $display("%0t: %0d sorted items never arrived", $time, sorted_expect.size());
        end

        $display("Sent %0d items in %0d sets (%0d sets overflowed the row), checked %0d",
                 items_accepted, sets_accepted, overflow_sets, results_checked);
        $display("sorted items under free flow, sparse sender, heavy back-pressure, %s",
                 "mixed idling and a long stall.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: run did not complete in time", $time);
        $display("FAILURE");
        $finish;
    end

endmodule
